// File: hdl/mr3_pkg.sv
// Shared types and encodings for the MIPS I integer core.
`default_nettype none
package mr3_pkg;

   // Input beat: instruction word or read data for a pending load
   typedef struct packed {
      logic        opcode;
      logic [31:0] instruction;
      logic [31:0] read_data;
      logic        irq_pending;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] fetch_pc;
      logic [31:0] bus_address;
      logic [31:0] write_data;
      logic [3:0]  byte_enable;
      logic [4:0]  exception_code;
   } rsp_type;

   // Item kinds
   localparam logic REQ_INSTR = 1'b0;
   localparam logic REQ_RDATA = 1'b1;

   // Result kinds
   localparam logic [2:0] K_RETIRE = 3'd0;
   localparam logic [2:0] K_READ   = 3'd1;
   localparam logic [2:0] K_WRITE  = 3'd2;
   localparam logic [2:0] K_EXC    = 3'd3;
   localparam logic [2:0] K_HALT   = 3'd4;

   // Cause codes
   localparam logic [4:0] EC_INT  = 5'd0;
   localparam logic [4:0] EC_ADDR = 5'd4;
   localparam logic [4:0] EC_SYS  = 5'd8;
   localparam logic [4:0] EC_BRK  = 5'd9;
   localparam logic [4:0] EC_OVF  = 5'd12;

   // Load merge types
   localparam logic [2:0] LT_B  = 3'd0;
   localparam logic [2:0] LT_BU = 3'd1;
   localparam logic [2:0] LT_H  = 3'd2;
   localparam logic [2:0] LT_HU = 3'd3;
   localparam logic [2:0] LT_W  = 3'd4;
   localparam logic [2:0] LT_WL = 3'd5;
   localparam logic [2:0] LT_WR = 3'd6;

   // Addresses and masks
   localparam logic [31:0] BOOT_VECTOR = 32'hbfc00000;
   localparam logic [31:0] RAM_VECTOR  = 32'h80000080;
   localparam logic [31:0] ROM_VECTOR  = 32'hbfc00180;
   localparam logic [31:0] GP0_PORT    = 32'h1f801810;
   localparam logic [31:0] GP1_PORT    = 32'h1f801814;
   localparam logic [31:0] ALL_ONES    = 32'hffffffff;

   // COP0 register numbers and status bits
   localparam logic [4:0] C0_BADA  = 5'd8;
   localparam logic [4:0] C0_SR    = 5'd12;
   localparam logic [4:0] C0_CAUSE = 5'd13;
   localparam logic [4:0] C0_EPC   = 5'd14;
   localparam int SR_IEC = 0;
   localparam int SR_IM2 = 10;
   localparam int SR_ISC = 16;
   localparam int SR_BEV = 22;
   localparam int CA_IP2 = 10;

   // COP0 sub-operations
   localparam logic [4:0] CO_MF = 5'd0;
   localparam logic [4:0] CO_MT = 5'd4;
   localparam logic [4:0] CO_CO = 5'd16;
   localparam logic [5:0] CO_RFE = 6'h10;

   // Major opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_COP2    = 6'h12;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LWL     = 6'h22;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_LWR     = 6'h26;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SWL     = 6'h2A;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_SWR     = 6'h2E;
   localparam logic [5:0] OP_LWC2    = 6'h32;
   localparam logic [5:0] OP_SWC2    = 6'h3A;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_BREAK   = 6'h0D;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1A;
   localparam logic [5:0] FN_DIVU    = 6'h1B;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

endpackage
`default_nettype wire

// File: hdl/mips_r3000_integer_core.sv
// MIPS I integer core: sequencer, register file, COP0 and shared multiply/divide unit.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_ready | mr3_pkg::req_type
//  rsp_    | out       | rsp_valid / rsp_ready | mr3_pkg::rsp_type
//
// Most items read the register file when accepted, then execute and commit in S_EXEC.
// MULT/MULTU/DIV/DIVU (nonzero divisor) then run the 32 one-bit steps of the shared
// 34-bit add/subtract unit in S_MD and commit HI/LO in S_MDEND.
// Reset clears control state, HI/LO, COP0 and the register file valid bits.
// A result waits in the output register; the core takes the next beat meanwhile,
// but an item's commit waits until that register is free (a multiply/divide starts anyway and waits in S_MDEND).
`default_nettype none
module mips_r3000_integer_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mr3_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mr3_pkg::rsp_type      rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MD, S_MDEND} state_type;

   state_type        state_ff;
   logic [4:0]       cnt_ff;
   logic             rsp_valid_ff;
   mr3_pkg::rsp_type rsp_data_ff;

   // Latched item
   logic        op_ff;
   logic [31:0] ins_ff;
   logic [31:0] rdata_ff;
   logic        irq_ff;

   // Architectural state
   logic [31:0] pc_ff, bt_ff, hi_ff, lo_ff;
   logic        bp_ff;
   logic [31:0] cop0_ff [32];
   logic        lw_ff;
   logic [4:0]  ld_dest_ff;
   logic [2:0]  ld_type_ff;
   logic [1:0]  ld_lane_ff;

   // Register file memory and valid bits
   logic [31:0] gpr_mem [32];
   logic [31:0] gpr_vld_ff;
   logic [31:0] rd_a_ff, rd_b_ff;
   logic        gv_a_ff, gv_b_ff;

   // Multiply/divide unit
   logic [31:0] md_hi_ff, md_lo_ff, md_d_ff;
   logic        md_div_ff, md_neg_q_ff, md_neg_r_ff;

   logic accept, slot_free;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode fields
   logic [5:0]  op, fn;
   logic [4:0]  ia, ib, id, sa, shamt, ra;
   logic [31:0] va, vb, sx, zx, ea, seq, pc4, pc8, btgt, sum_ab, dif_ab;
   logic [31:0] cause_cur, c0_rd, sr;
   assign op  = ins_ff[31:26];
   assign fn  = ins_ff[5:0];
   assign ia  = ins_ff[25:21];
   assign ib  = ins_ff[20:16];
   assign id  = ins_ff[15:11];
   assign sa  = ins_ff[10:6];
   assign va  = gv_a_ff ? rd_a_ff : 32'd0;
   assign vb  = gv_b_ff ? rd_b_ff : 32'd0;
   assign sx  = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign zx  = {16'd0, ins_ff[15:0]};
   assign ea  = va + sx;
   assign pc4 = pc_ff + 32'd4;
   assign pc8 = pc_ff + 32'd8;
   assign seq = bp_ff ? bt_ff : pc4;
   assign btgt = pc4 + {sx[29:0], 2'b00};
   assign sum_ab = va + vb;
   assign dif_ab = va - vb;
   assign shamt = fn[2] ? va[4:0] : sa;
   assign sr = cop0_ff[mr3_pkg::C0_SR];
   assign cause_cur = {cop0_ff[mr3_pkg::C0_CAUSE][31:11], irq_ff,
                       cop0_ff[mr3_pkg::C0_CAUSE][9:0]};
   assign c0_rd = (id == mr3_pkg::C0_CAUSE) ? cause_cur : cop0_ff[id];
   assign ra = req_data.opcode ? ld_dest_ff : req_data.instruction[25:21];

   // Execute decode
   logic        x_trap, x_halt, x_bad_we, gw, hi_we, lo_we, c0_we, rfe, jmp;
   logic        is_ld, is_st, md_go, md_div, md_sgn, half, word, port;
   logic [4:0]  x_code, gwa;
   logic [31:0] x_bad, gwd, hi_v, lo_v, tgt, sdata;
   logic [2:0]  ltype;
   logic [3:0]  lbe, sbe;

   always_comb begin
      x_trap = 1'b0; x_halt = 1'b0; x_code = mr3_pkg::EC_INT;
      x_bad_we = 1'b0; x_bad = ea;
      gw = 1'b0; gwa = id; gwd = 32'd0;
      hi_we = 1'b0; lo_we = 1'b0; hi_v = va; lo_v = va;
      c0_we = 1'b0; rfe = 1'b0; jmp = 1'b0; tgt = btgt;
      is_ld = 1'b0; is_st = 1'b0; ltype = mr3_pkg::LT_W; lbe = 4'hf;
      sdata = 32'd0; sbe = 4'hf;
      md_go = 1'b0; md_div = 1'b0; md_sgn = 1'b0;
      half = 1'b0; word = 1'b0; port = 1'b0;
      if (irq_ff && sr[mr3_pkg::SR_IEC] && sr[mr3_pkg::SR_IM2]) begin
         x_trap = 1'b1;
      end else begin
         unique case (op)
            mr3_pkg::OP_SPECIAL: begin
               unique case (fn)
                  mr3_pkg::FN_SLL, mr3_pkg::FN_SLLV: begin
                     gw = 1'b1; gwd = vb << shamt;
                  end
                  mr3_pkg::FN_SRL, mr3_pkg::FN_SRLV: begin
                     gw = 1'b1; gwd = vb >> shamt;
                  end
                  mr3_pkg::FN_SRA, mr3_pkg::FN_SRAV: begin
                     gw = 1'b1; gwd = $unsigned($signed(vb) >>> shamt);
                  end
                  mr3_pkg::FN_JR, mr3_pkg::FN_JALR: begin
                     if (va[1:0] != 2'd0) begin
                        x_trap = 1'b1; x_code = mr3_pkg::EC_ADDR;
                        x_bad_we = 1'b1; x_bad = va;
                     end else begin
                        gw = (fn == mr3_pkg::FN_JALR); gwd = pc8;
                        jmp = 1'b1; tgt = va;
                     end
                  end
                  mr3_pkg::FN_SYSCALL: begin
                     x_trap = 1'b1; x_code = mr3_pkg::EC_SYS;
                  end
                  mr3_pkg::FN_BREAK: begin
                     x_trap = 1'b1; x_code = mr3_pkg::EC_BRK;
                  end
                  mr3_pkg::FN_MFHI: begin gw = 1'b1; gwd = hi_ff; end
                  mr3_pkg::FN_MTHI: hi_we = 1'b1;
                  mr3_pkg::FN_MFLO: begin gw = 1'b1; gwd = lo_ff; end
                  mr3_pkg::FN_MTLO: lo_we = 1'b1;
                  mr3_pkg::FN_MULT: begin md_go = 1'b1; md_sgn = 1'b1; end
                  mr3_pkg::FN_MULTU: md_go = 1'b1;
                  mr3_pkg::FN_DIV: begin
                     if (vb == 32'd0) begin
                        hi_we = 1'b1; lo_we = 1'b1;
                        lo_v = va[31] ? 32'd1 : mr3_pkg::ALL_ONES;
                     end else begin
                        md_go = 1'b1; md_div = 1'b1; md_sgn = 1'b1;
                     end
                  end
                  mr3_pkg::FN_DIVU: begin
                     if (vb == 32'd0) begin
                        hi_we = 1'b1; lo_we = 1'b1; lo_v = mr3_pkg::ALL_ONES;
                     end else begin
                        md_go = 1'b1; md_div = 1'b1;
                     end
                  end
                  mr3_pkg::FN_ADD: begin
                     if (((va ^ sum_ab) & (vb ^ sum_ab)) >> 31 != 32'd0) begin
                        x_trap = 1'b1; x_code = mr3_pkg::EC_OVF;
                     end else begin
                        gw = 1'b1; gwd = sum_ab;
                     end
                  end
                  mr3_pkg::FN_ADDU: begin gw = 1'b1; gwd = sum_ab; end
                  mr3_pkg::FN_SUB: begin
                     if (((va ^ vb) & (va ^ dif_ab)) >> 31 != 32'd0) begin
                        x_trap = 1'b1; x_code = mr3_pkg::EC_OVF;
                     end else begin
                        gw = 1'b1; gwd = dif_ab;
                     end
                  end
                  mr3_pkg::FN_SUBU: begin gw = 1'b1; gwd = dif_ab; end
                  mr3_pkg::FN_AND: begin gw = 1'b1; gwd = va & vb; end
                  mr3_pkg::FN_OR:  begin gw = 1'b1; gwd = va | vb; end
                  mr3_pkg::FN_XOR: begin gw = 1'b1; gwd = va ^ vb; end
                  mr3_pkg::FN_NOR: begin gw = 1'b1; gwd = ~(va | vb); end
                  mr3_pkg::FN_SLT: begin
                     gw = 1'b1; gwd = {31'd0, $signed(va) < $signed(vb)};
                  end
                  mr3_pkg::FN_SLTU: begin gw = 1'b1; gwd = {31'd0, va < vb}; end
                  default: x_halt = 1'b1;
               endcase
            end
            mr3_pkg::OP_REGIMM: begin
               gw = ib[4]; gwa = 5'd31; gwd = pc8;
               jmp = ib[0] ? !va[31] : va[31];
            end
            mr3_pkg::OP_J, mr3_pkg::OP_JAL: begin
               gw = (op == mr3_pkg::OP_JAL); gwa = 5'd31; gwd = pc8;
               jmp = 1'b1; tgt = {pc4[31:28], ins_ff[25:0], 2'b00};
            end
            mr3_pkg::OP_BEQ:  jmp = (va == vb);
            mr3_pkg::OP_BNE:  jmp = (va != vb);
            mr3_pkg::OP_BLEZ: jmp = va[31] || (va == 32'd0);
            mr3_pkg::OP_BGTZ: jmp = !va[31] && (va != 32'd0);
            mr3_pkg::OP_ADDI: begin
               gwa = ib;
               if (((va ^ ea) & (sx ^ ea)) >> 31 != 32'd0) begin
                  x_trap = 1'b1; x_code = mr3_pkg::EC_OVF;
               end else begin
                  gw = 1'b1; gwd = ea;
               end
            end
            mr3_pkg::OP_ADDIU: begin gw = 1'b1; gwa = ib; gwd = ea; end
            mr3_pkg::OP_SLTI: begin
               gw = 1'b1; gwa = ib; gwd = {31'd0, $signed(va) < $signed(sx)};
            end
            mr3_pkg::OP_SLTIU: begin gw = 1'b1; gwa = ib; gwd = {31'd0, va < sx}; end
            mr3_pkg::OP_ANDI: begin gw = 1'b1; gwa = ib; gwd = va & zx; end
            mr3_pkg::OP_ORI:  begin gw = 1'b1; gwa = ib; gwd = va | zx; end
            mr3_pkg::OP_XORI: begin gw = 1'b1; gwa = ib; gwd = va ^ zx; end
            mr3_pkg::OP_LUI:  begin gw = 1'b1; gwa = ib; gwd = {ins_ff[15:0], 16'd0}; end
            mr3_pkg::OP_COP0: begin
               if (ia == mr3_pkg::CO_MF) begin
                  gw = 1'b1; gwa = ib; gwd = c0_rd;
               end else if (ia == mr3_pkg::CO_MT) begin
                  c0_we = 1'b1;
               end else if (ia == mr3_pkg::CO_CO && fn == mr3_pkg::CO_RFE) begin
                  rfe = 1'b1;
               end else begin
                  x_halt = 1'b1;
               end
            end
            mr3_pkg::OP_COP2, mr3_pkg::OP_LWC2, mr3_pkg::OP_SWC2: begin
               jmp = 1'b0;
            end
            mr3_pkg::OP_LB: begin
               is_ld = 1'b1; ltype = mr3_pkg::LT_B; lbe = 4'b0001 << ea[1:0];
            end
            mr3_pkg::OP_LBU: begin
               is_ld = 1'b1; ltype = mr3_pkg::LT_BU; lbe = 4'b0001 << ea[1:0];
            end
            mr3_pkg::OP_LH: begin
               is_ld = 1'b1; ltype = mr3_pkg::LT_H; lbe = 4'b0011 << {ea[1], 1'b0};
            end
            mr3_pkg::OP_LHU: begin
               is_ld = 1'b1; ltype = mr3_pkg::LT_HU; lbe = 4'b0011 << {ea[1], 1'b0};
            end
            mr3_pkg::OP_LW: is_ld = 1'b1;
            mr3_pkg::OP_LWL: begin
               is_ld = 1'b1; ltype = mr3_pkg::LT_WL;
               lbe = ~(4'b1110 << ea[1:0]);
            end
            mr3_pkg::OP_LWR: begin
               is_ld = 1'b1; ltype = mr3_pkg::LT_WR; lbe = 4'b1111 << ea[1:0];
            end
            mr3_pkg::OP_SB: begin
               is_st = 1'b1; sdata = vb << {ea[1:0], 3'b000};
               sbe = 4'b0001 << ea[1:0];
            end
            mr3_pkg::OP_SH: begin
               is_st = 1'b1; sdata = vb << {ea[1], 4'b0000};
               sbe = 4'b0011 << {ea[1], 1'b0};
            end
            mr3_pkg::OP_SW: begin is_st = 1'b1; sdata = vb; end
            mr3_pkg::OP_SWL: begin
               is_st = 1'b1; sdata = vb >> {~ea[1:0], 3'b000};
               sbe = ~(4'b1110 << ea[1:0]);
            end
            mr3_pkg::OP_SWR: begin
               is_st = 1'b1; sdata = vb << {ea[1:0], 3'b000};
               sbe = 4'b1111 << ea[1:0];
            end
            default: x_halt = 1'b1;
         endcase
         // Alignment check, then cache isolation
         if (is_ld || is_st) begin
            half = (op == mr3_pkg::OP_LH) || (op == mr3_pkg::OP_LHU) ||
                   (op == mr3_pkg::OP_SH);
            word = (op == mr3_pkg::OP_LW) || (op == mr3_pkg::OP_SW);
            port = (op == mr3_pkg::OP_SW) &&
                   ((ea == mr3_pkg::GP0_PORT) || (ea == mr3_pkg::GP1_PORT));
            if ((half && ea[0]) || (word && (ea[1:0] != 2'd0))) begin
               x_trap = 1'b1; x_code = mr3_pkg::EC_ADDR; x_bad_we = 1'b1;
            end else if (sr[mr3_pkg::SR_ISC] && !port) begin
               is_ld = 1'b0; is_st = 1'b0;
            end
         end
      end
   end

   // Load merge for the returned word
   logic [4:0]  s8;
   logic [31:0] w, byt, hwd, keep_l, keep_r, mrg;
   assign s8  = {ld_lane_ff, 3'b000};
   assign w   = rdata_ff;
   assign byt = w >> s8;
   assign hwd = w >> s8;
   assign keep_l = (ld_lane_ff == 2'd3) ? 32'd0 : (mr3_pkg::ALL_ONES >> ({1'b0, s8} + 6'd8));
   assign keep_r = (ld_lane_ff == 2'd0) ? 32'd0 : ~(mr3_pkg::ALL_ONES >> (6'd32 - {1'b0, s8}));
   always_comb begin
      unique case (ld_type_ff)
         mr3_pkg::LT_B:  mrg = {{24{byt[7]}}, byt[7:0]};
         mr3_pkg::LT_BU: mrg = {24'd0, byt[7:0]};
         mr3_pkg::LT_H:  mrg = {{16{hwd[15]}}, hwd[15:0]};
         mr3_pkg::LT_HU: mrg = {16'd0, hwd[15:0]};
         mr3_pkg::LT_WL: mrg = (va & keep_l) | (w << (5'd24 - s8));
         mr3_pkg::LT_WR: mrg = (va & keep_r) | (w >> s8);
         default:        mrg = w;
      endcase
   end

   // Commit conditions
   logic ex_do, reply_go, instr_ok, instr_go, normal, md_fin;
   assign ex_do    = (state_ff == S_EXEC);
   assign reply_go = ex_do && (op_ff == mr3_pkg::REQ_RDATA) && lw_ff && slot_free;
   assign instr_ok = ex_do && (op_ff == mr3_pkg::REQ_INSTR) && !lw_ff;
   assign normal   = !x_trap && !x_halt;
   assign instr_go = instr_ok && (slot_free || (md_go && normal));
   assign md_fin   = (state_ff == S_MDEND) && slot_free;

   // Register file write port
   logic        gpr_we;
   logic [4:0]  gpr_wa;
   logic [31:0] gpr_wd;
   always_comb begin
      gpr_we = 1'b0; gpr_wa = gwa; gpr_wd = gwd;
      if (reply_go) begin
         gpr_we = (ld_dest_ff != 5'd0); gpr_wa = ld_dest_ff; gpr_wd = mrg;
      end else if (instr_go && normal && gw) begin
         gpr_we = (gwa != 5'd0);
      end
   end

   // Shared add/subtract for multiply and divide steps
   logic [32:0] md_sh;
   logic [33:0] md_sum;
   logic [63:0] prod_neg;
   logic [31:0] hi_res, lo_res, mag_a, mag_b;
   assign md_sh  = {md_hi_ff, md_lo_ff[31]};
   assign md_sum = md_div_ff ? ({1'b0, md_sh} - {2'b00, md_d_ff})
                             : ({2'b00, md_hi_ff} + (md_lo_ff[0] ? {2'b00, md_d_ff} : 34'd0));
   assign prod_neg = 64'd0 - {md_hi_ff, md_lo_ff};
   assign hi_res = md_div_ff ? (md_neg_r_ff ? 32'd0 - md_hi_ff : md_hi_ff)
                             : (md_neg_q_ff ? prod_neg[63:32] : md_hi_ff);
   assign lo_res = md_div_ff ? (md_neg_q_ff ? 32'd0 - md_lo_ff : md_lo_ff)
                             : (md_neg_q_ff ? prod_neg[31:0] : md_lo_ff);
   assign mag_a = (md_sgn && va[31]) ? 32'd0 - va : va;
   assign mag_b = (md_sgn && vb[31]) ? 32'd0 - vb : vb;

   // Register file storage and registered reads
   always_ff @(posedge clock) begin
      if (gpr_we) begin
         gpr_mem[gpr_wa] <= gpr_wd;
      end
      if (accept) begin
         rd_a_ff <= gpr_mem[ra];
         rd_b_ff <= gpr_mem[req_data.instruction[20:16]];
      end
   end

   // Datapath registers without reset
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_data.opcode;
         ins_ff   <= req_data.instruction;
         rdata_ff <= req_data.read_data;
         irq_ff   <= req_data.irq_pending;
      end
      if (instr_go && normal && md_go) begin
         md_div_ff   <= md_div;
         md_hi_ff    <= 32'd0;
         md_neg_q_ff <= md_sgn && (va[31] ^ vb[31]);
         md_neg_r_ff <= md_sgn && va[31];
         md_d_ff     <= md_div ? mag_b : mag_a;
         md_lo_ff    <= md_div ? mag_a : mag_b;
      end else if (state_ff == S_MD) begin
         if (md_div_ff) begin
            md_hi_ff <= md_sum[33] ? md_sh[31:0] : md_sum[31:0];
            md_lo_ff <= {md_lo_ff[30:0], !md_sum[33]};
         end else begin
            md_hi_ff <= md_sum[32:1];
            md_lo_ff <= {md_sum[0], md_lo_ff[31:1]};
         end
      end
   end

   // Sequencer, architectural state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         pc_ff        <= mr3_pkg::BOOT_VECTOR;
         bp_ff        <= 1'b0;
         bt_ff        <= 32'd0;
         hi_ff        <= 32'd0;
         lo_ff        <= 32'd0;
         lw_ff        <= 1'b0;
         ld_dest_ff   <= 5'd0;
         ld_type_ff   <= mr3_pkg::LT_B;
         ld_lane_ff   <= 2'd0;
         gpr_vld_ff   <= 32'd0;
         gv_a_ff      <= 1'b0;
         gv_b_ff      <= 1'b0;
         for (int i = 0; i < 32; i++) begin
            cop0_ff[i] <= 32'd0;
         end
      end else begin
         // drop a delivered beat
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (gpr_we) begin
            gpr_vld_ff[gpr_wa] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  gv_a_ff  <= gpr_vld_ff[ra];
                  gv_b_ff  <= gpr_vld_ff[req_data.instruction[20:16]];
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (op_ff == mr3_pkg::REQ_RDATA) begin
                  if (!lw_ff) begin
                     state_ff <= S_IDLE;
                  end else if (reply_go) begin
                     lw_ff        <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= '{mr3_pkg::K_RETIRE, pc_ff, 32'd0, 32'd0,
                                       4'd0, 5'd0};
                     state_ff     <= S_IDLE;
                  end
               end else if (lw_ff) begin
                  state_ff <= S_IDLE;
               end else if (instr_go) begin
                  cop0_ff[mr3_pkg::C0_CAUSE] <= cause_cur;
                  state_ff <= S_IDLE;
                  if (x_trap) begin
                     // exception entry
                     cop0_ff[mr3_pkg::C0_SR] <= {sr[31:6], sr[3:0], 2'b00};
                     cop0_ff[mr3_pkg::C0_CAUSE] <= {bp_ff, 15'd0,
                        cause_cur[15:8], 1'b0, x_code, 2'b00};
                     cop0_ff[mr3_pkg::C0_EPC] <= bp_ff ? pc_ff - 32'd4 : pc_ff;
                     if (x_bad_we) begin
                        cop0_ff[mr3_pkg::C0_BADA] <= x_bad;
                     end
                     pc_ff <= sr[mr3_pkg::SR_BEV] ? mr3_pkg::ROM_VECTOR
                                                  : mr3_pkg::RAM_VECTOR;
                     bp_ff <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= '{mr3_pkg::K_EXC,
                        sr[mr3_pkg::SR_BEV] ? mr3_pkg::ROM_VECTOR : mr3_pkg::RAM_VECTOR,
                        32'd0, 32'd0, 4'd0, x_code};
                  end else if (x_halt) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= '{mr3_pkg::K_HALT, pc_ff, 32'd0, 32'd0,
                                       4'd0, 5'd0};
                  end else begin
                     if (rfe) begin
                        cop0_ff[mr3_pkg::C0_SR] <= {sr[31:4], sr[5:2]};
                     end
                     if (c0_we) begin
                        cop0_ff[id] <= vb;
                     end
                     if (hi_we) begin
                        hi_ff <= hi_v;
                     end
                     if (lo_we) begin
                        lo_ff <= lo_v;
                     end
                     pc_ff <= seq;
                     bp_ff <= jmp;
                     if (jmp) begin
                        bt_ff <= tgt;
                     end
                     if (md_go) begin
                        cnt_ff   <= 5'd0;
                        state_ff <= S_MD;
                     end else if (is_ld) begin
                        lw_ff        <= 1'b1;
                        ld_dest_ff   <= ib;
                        ld_type_ff   <= ltype;
                        ld_lane_ff   <= ea[1:0];
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= '{mr3_pkg::K_READ, seq, {ea[31:2], 2'b00},
                                          32'd0, lbe, 5'd0};
                     end else if (is_st) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= '{mr3_pkg::K_WRITE, seq, {ea[31:2], 2'b00},
                                          sdata, sbe, 5'd0};
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= '{mr3_pkg::K_RETIRE, seq, 32'd0, 32'd0,
                                          4'd0, 5'd0};
                     end
                  end
               end
            end
            S_MD: begin
               // advance one multiply or divide bit
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= S_MDEND;
               end
            end
            S_MDEND: begin
               if (md_fin) begin
                  hi_ff        <= hi_res;
                  lo_ff        <= lo_res;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{mr3_pkg::K_RETIRE, pc_ff, 32'd0, 32'd0,
                                    4'd0, 5'd0};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks
   a_busy_md: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MD) |-> !req_ready)
      else $error("core ready during multiply/divide");
   a_md_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MD && cnt_ff == 5'd31) |=> (state_ff == S_MDEND))
      else $error("multiply/divide step count broken");
   a_read_pend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == mr3_pkg::K_READ) |-> lw_ff)
      else $error("read request without pending load");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result beat lost");

endmodule
`default_nettype wire
